// ===== hdl/bsa_pkg.sv =====
// Shared types and constants for the bitmap slot allocator.
// No dependencies; imported by bitmap_slot_allocator.
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 256;
    localparam int SLOT_W    = $clog2(POOL_SIZE);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int WORDS     = POOL_SIZE / WORD_W;
    localparam int WADDR_W   = $clog2(WORDS);

    // Field widths
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;
    localparam int SB_W   = 16;
    localparam int OFS_W  = SLOT_W + SB_W;
    localparam int CFG_W  = SB_W;

    localparam logic [CNT_W-1:0] CNT_MAX  = '1;
    localparam logic [CNT_W-1:0] POOL_CAP = CNT_W'(POOL_SIZE);

    // Configuration register indexes
    typedef enum logic {
        CFG_POOL_SLOTS = 1'b0,
        CFG_SLOT_BYTES = 1'b1
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_PUSH  = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/bsa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the allocation bitmap words.
`timescale 1ns / 1ps
`default_nettype none

module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/bitmap_slot_allocator.sv =====
// Bitmap slot allocator, first fit: bitmap in RAM words, counts in registers.
// Depends on bsa_pkg and bsa_ram.
//
// Usage:
//   s_axis carries one request per transfer: mode and slot_index. m_axis
//   returns one result per request: status, granted slot, byte offset and
//   both counts after the operation. cfg_* writes pool_slots (index 0) and
//   slot_bytes (index 1); write only while no request is in flight.
// Sequencing (one request at a time):
//   Requests that fail their range check skip the bitmap and go straight to the result.
//   Free and push: one RAM read, then one read-modify-write.
//   Allocate: one RAM read and evaluation per 32-slot bitmap word scanned (up to 8 words).
//   Mark all free: one read and write per bitmap word, sweeping all 8 bitmap words.
//   Each word is read from the bitmap RAM, whose read data is registered, before
//   it is evaluated.
// Reset: every slot reads as allocated (per-word valid flags, no clearing
//   pass), both counts zero, pool_slots 256, slot_bytes 1.
// Stall: the result sits in an output register; the next request is taken
//   while it waits, and that request's result holds until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_slot_allocator
    import bsa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration write port
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    // request channel
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [15:0]      s_axis_tdata,  // [1:0] mode, [9:2] slot_index, rest zero
    // result channel
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [55:0]           m_axis_tdata   // [1:0] status, [9:2] granted_slot,
                                                 // [33:10] byte_offset, [42:34] slots_in_use,
                                                 // [51:43] slots_available, rest zero
);

    // Configuration registers
    logic [CNT_W-1:0] pool_slots_reg;
    logic [SB_W-1:0]  slot_bytes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_slots_reg <= POOL_CAP;
            slot_bytes_reg <= SB_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_POOL_SLOTS: pool_slots_reg <= cfg_data[CNT_W-1:0];
                CFG_SLOT_BYTES: slot_bytes_reg <= cfg_data[SB_W-1:0];
                default: ;
            endcase
        end
    end

    // Request state
    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [WADDR_W-1:0] word_reg, word_next;
    status_t            status_reg, status_next;
    logic [SLOT_W-1:0]  granted_reg, granted_next;
    logic [CNT_W-1:0]   in_use_reg, in_use_next;
    logic [CNT_W-1:0]   avail_reg, avail_next;
    logic [WORDS-1:0]   valid_reg, valid_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic [55:0]        m_data_reg, m_data_next;

    logic s_accept;
    logic out_free;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Bitmap RAM
    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    bsa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(WORDS)
    ) u_bitmap (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(word_reg),
        .wdata(ram_wdata),
        .raddr(word_reg),
        .rdata(ram_rdata)
    );

    // Capacity and scan limit
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] limit;
    assign cap   = (pool_slots_reg > POOL_CAP) ? POOL_CAP : pool_slots_reg;
    assign limit = (avail_reg < cap) ? avail_reg : cap;

    // Request decode at the input
    mode_t             in_mode;
    logic [SLOT_W-1:0] in_idx;
    assign in_mode = mode_t'(s_axis_tdata[MODE_W-1:0]);
    assign in_idx  = s_axis_tdata[MODE_W +: SLOT_W];

    // Word evaluation: unwritten words read as all allocated
    logic [WORD_W-1:0]  rd_word;
    logic [WORD_W-1:0]  lim_mask, clr_mask;
    logic [WORD_W-1:0]  free_bits, lowest;
    logic [BIT_W-1:0]   low_idx;
    logic               found;
    logic [BIT_W-1:0]   sel_pos;
    logic [WORD_W-1:0]  sel_bit;
    logic [WADDR_W:0]   word_inc;
    logic               scan_end;
    logic               last_word;

    always_comb begin
        rd_word = valid_reg[word_reg] ? ram_rdata : '1;
        for (int j = 0; j < WORD_W; j++) begin
            lim_mask[j] = {1'b0, word_reg, BIT_W'(j)} < limit;
            clr_mask[j] = {1'b0, word_reg, BIT_W'(j)} < cap;
        end
        free_bits = ~rd_word & lim_mask;
        lowest    = free_bits & (~free_bits + WORD_W'(1));
        found     = |free_bits;
        low_idx   = '0;
        for (int j = 0; j < WORD_W; j++) begin
            if (lowest[j]) begin
                low_idx = low_idx | BIT_W'(j);
            end
        end
        sel_pos   = (mode_reg == MODE_PUSH) ? avail_reg[BIT_W-1:0] : idx_reg[BIT_W-1:0];
        sel_bit   = WORD_W'(1) << sel_pos;
        word_inc  = {1'b0, word_reg} + (WADDR_W+1)'(1);
        scan_end  = {word_inc, BIT_W'(0)} >= limit;
        last_word = (word_reg == WADDR_W'(WORDS - 1));
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    case (in_mode)
                        MODE_ALLOC: state_next = (limit == '0) ? S_DONE : S_READ;
                        MODE_FREE:  state_next = ({1'b0, in_idx} >= cap) ? S_DONE : S_READ;
                        MODE_PUSH:  state_next = (avail_reg >= cap) ? S_DONE : S_READ;
                        default:    state_next = S_READ;
                    endcase
                end
            end
            S_READ: state_next = S_EVAL;
            S_EVAL: begin
                case (mode_reg)
                    MODE_ALLOC: state_next = (found || scan_end) ? S_DONE : S_READ;
                    MODE_CLEAR: state_next = last_word ? S_DONE : S_READ;
                    default:    state_next = S_DONE;
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        mode_next    = mode_reg;
        idx_next     = idx_reg;
        word_next    = word_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        in_use_next  = in_use_reg;
        avail_next   = avail_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_wdata    = rd_word;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    mode_next    = in_mode;
                    idx_next     = in_idx;
                    granted_next = '0;
                    word_next    = '0;
                    status_next  = STAT_OK;
                    case (in_mode)
                        MODE_ALLOC: status_next = STAT_EMPTY;
                        MODE_FREE: begin
                            word_next = in_idx[SLOT_W-1 -: WADDR_W];
                            if ({1'b0, in_idx} >= cap) begin
                                status_next = STAT_RANGE;
                            end
                        end
                        MODE_PUSH: begin
                            word_next = avail_reg[SLOT_W-1 -: WADDR_W];
                            if (avail_reg >= cap) begin
                                status_next = STAT_FULL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: ;
            S_EVAL: begin
                case (mode_reg)
                    MODE_ALLOC: begin
                        if (found) begin
                            ram_we       = 1'b1;
                            ram_wdata    = rd_word | lowest;
                            granted_next = {word_reg, low_idx};
                            status_next  = STAT_OK;
                            if (in_use_reg != CNT_MAX) begin
                                in_use_next = in_use_reg + CNT_W'(1);
                            end
                        end else begin
                            word_next = word_inc[WADDR_W-1:0];
                        end
                    end
                    MODE_FREE: begin
                        if (|(rd_word & sel_bit)) begin
                            ram_we    = 1'b1;
                            ram_wdata = rd_word & ~sel_bit;
                            if (in_use_reg != '0) begin
                                in_use_next = in_use_reg - CNT_W'(1);
                            end
                        end
                    end
                    MODE_PUSH: begin
                        ram_we       = 1'b1;
                        ram_wdata    = rd_word | sel_bit;
                        granted_next = avail_reg[SLOT_W-1:0];
                        avail_next   = avail_reg + CNT_W'(1);
                    end
                    default: begin
                        // mark all free: clear only slots below the capacity
                        ram_we    = 1'b1;
                        ram_wdata = rd_word & ~clr_mask;
                        word_next = word_inc[WADDR_W-1:0];
                        if (last_word) begin
                            avail_next  = cap;
                            in_use_next = '0;
                        end
                    end
                endcase
                if (ram_we) begin
                    valid_next[word_reg] = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, avail_reg, in_use_reg,
                                    OFS_W'(granted_reg * slot_bytes_reg),
                                    granted_reg, status_reg};
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            in_use_reg  <= '0;
            avail_reg   <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_use_reg  <= in_use_next;
            avail_reg   <= avail_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        idx_reg     <= idx_next;
        word_reg    <= word_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        m_data_reg  <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // available count never passes the pool size
    assert property (@(posedge aclk) disable iff (!aresetn)
        avail_reg <= POOL_CAP)
        else $error("available count above pool size");

    // a failed request carries no slot and no offset
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata[1:0] != STAT_OK))
            |-> (m_axis_tdata[33:2] == '0))
        else $error("granted slot on a failed request");

    // the in-use count moves only while a bitmap word is evaluated
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(in_use_reg)) |-> ($past(state_reg) == S_EVAL))
        else $error("in-use count changed outside word evaluation");

    // no new request is taken while one is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_axis_tready)
        else $error("request accepted during another request");
`endif

endmodule

`default_nettype wire
